// File: src/lr_pkg.sv
// Shared types and constants for the line rasterizer.
package lr_pkg;

  localparam int FIELD_W     = 16;           // coordinate field width on the ports
  localparam int COORD_W     = 16;           // live coordinate bits, 9..16
  localparam int ERR_W       = COORD_W + 2;  // error term spans [-dy, dx]
  localparam int COLOR_W     = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // One classified command as the front hands it to the back.
  typedef struct packed {
    logic                    is_start;
    logic [COORD_W-1:0]      x0;
    logic [COORD_W-1:0]      y0;
    logic [COORD_W-1:0]      x1;
    logic [COORD_W-1:0]      y1;
    logic [COORD_W-1:0]      dx;
    logic [COORD_W-1:0]      dy;
    logic                    x_neg;
    logic                    y_neg;
    logic signed [ERR_W-1:0] err0;
    logic                    zero_len;
  } line_cmd_t;

  typedef struct packed {
    logic      valid;
    line_cmd_t cmd;
  } cmd_word_t;

endpackage

// File: src/lr_cmd_if.sv
// Command channel: opcode and line endpoints.
interface lr_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [lr_pkg::FIELD_W-1:0]  start_x;
  logic [lr_pkg::FIELD_W-1:0]  start_y;
  logic [lr_pkg::FIELD_W-1:0]  end_x;
  logic [lr_pkg::FIELD_W-1:0]  end_y;

  modport source(output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: src/lr_pix_if.sv
// Pixel channel: one result word per command.
interface lr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [lr_pkg::FIELD_W-1:0]  pixel_x;
  logic [lr_pkg::FIELD_W-1:0]  pixel_y;
  logic [lr_pkg::COLOR_W-1:0]  pixel_color;
  logic                        pixel_valid;
  logic                        last_pixel;

  modport source(output valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
               output ready);
endinterface

// File: src/lr_front.sv
// Front end: accepts command words and precomputes deltas, directions and initial error.
module lr_front (
  lr_cmd_if.sink           cmd,
  input  logic             q_full,
  output lr_pkg::cmd_word_t push
);

  logic [lr_pkg::COORD_W-1:0] sx, sy, ex, ey, dx, dy;
  logic [lr_pkg::ERR_W-1:0]   half_dx, half_dy;

  assign sx = cmd.start_x[lr_pkg::COORD_W-1:0];
  assign sy = cmd.start_y[lr_pkg::COORD_W-1:0];
  assign ex = cmd.end_x[lr_pkg::COORD_W-1:0];
  assign ey = cmd.end_y[lr_pkg::COORD_W-1:0];

  assign dx = (ex > sx) ? ex - sx : sx - ex;
  assign dy = (ey > sy) ? ey - sy : sy - ey;

  assign half_dx = lr_pkg::ERR_W'(dx >> 1);
  assign half_dy = lr_pkg::ERR_W'(dy >> 1);

  assign cmd.ready = !q_full;

  always_comb begin
    push.valid        = cmd.valid && !q_full;
    push.cmd.is_start = (lr_pkg::opcode_t'(cmd.opcode) == lr_pkg::OP_START);
    push.cmd.x0       = sx;
    push.cmd.y0       = sy;
    push.cmd.x1       = ex;
    push.cmd.y1       = ey;
    push.cmd.dx       = dx;
    push.cmd.dy       = dy;
    push.cmd.x_neg    = !(sx < ex);
    push.cmd.y_neg    = !(sy < ey);
    // x-major lines start at dx/2, the rest at -(dy/2)
    push.cmd.err0     = (dx > dy) ? $signed(half_dx) : $signed(lr_pkg::ERR_W'(0) - half_dy);
    push.cmd.zero_len = (sx == ex) && (sy == ey);
  end

endmodule

// File: src/lr_queue.sv
// Two-entry command queue between front and back.
module lr_queue (
  input  logic              clk,
  input  logic              rst,
  input  lr_pkg::cmd_word_t push,
  input  logic              pop,
  output logic              full,
  output lr_pkg::cmd_word_t head
);

  lr_pkg::line_cmd_t          entries [lr_pkg::QUEUE_DEPTH];
  logic [lr_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [lr_pkg::QCNT_W-1:0]  count;
  logic                       do_pop;

  assign full       = (count == lr_pkg::QCNT_W'(lr_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + lr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + lr_pkg::QPTR_W'(1);
      end
      if (push.valid && !do_pop) begin
        count <= count + lr_pkg::QCNT_W'(1);
      end else if (!push.valid && do_pop) begin
        count <= count - lr_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

endmodule

// File: src/lr_back.sv
// Back end: Bresenham stepper with a registered pixel output.
module lr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  lr_pkg::cmd_word_t          head,
  input  logic [lr_pkg::COLOR_W-1:0] draw_color,
  output logic                       pop,
  lr_pix_if.source                   pix
);

  logic [lr_pkg::COORD_W-1:0] cur_x, cur_y, target_x, target_y, delta_x, delta_y;
  logic                       dir_x_negative, dir_y_negative, busy;
  logic signed [lr_pkg::ERR_W-1:0] error_term;

  logic [lr_pkg::COORD_W-1:0] cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic [lr_pkg::COORD_W-1:0] delta_x_next, delta_y_next;
  logic                       dir_x_negative_next, dir_y_negative_next, busy_next;
  logic signed [lr_pkg::ERR_W-1:0] error_term_next;

  logic signed [lr_pkg::ERR_W-1:0] dx_ext, dy_ext, neg_dx;
  logic                            move_x, move_y;
  logic [lr_pkg::COORD_W-1:0]      step_x, step_y;
  logic                            res_valid, res_last;

  logic                       out_valid;
  logic [lr_pkg::FIELD_W-1:0] out_x, out_y;
  logic [lr_pkg::COLOR_W-1:0] out_color;
  logic                       out_pixel_valid, out_last;

  assign pop = head.valid && (!out_valid || pix.ready);

  assign dx_ext = $signed(lr_pkg::ERR_W'(delta_x));
  assign dy_ext = $signed(lr_pkg::ERR_W'(delta_y));
  assign neg_dx = -dx_ext;

  // both tests look at the error before this step
  assign move_x = (error_term > neg_dx);
  assign move_y = (error_term < dy_ext);
  assign step_x = dir_x_negative ? cur_x - lr_pkg::COORD_W'(1) : cur_x + lr_pkg::COORD_W'(1);
  assign step_y = dir_y_negative ? cur_y - lr_pkg::COORD_W'(1) : cur_y + lr_pkg::COORD_W'(1);

  always_comb begin
    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    target_x_next       = target_x;
    target_y_next       = target_y;
    delta_x_next        = delta_x;
    delta_y_next        = delta_y;
    dir_x_negative_next = dir_x_negative;
    dir_y_negative_next = dir_y_negative;
    error_term_next     = error_term;
    busy_next           = busy;
    res_valid           = 1'b0;
    res_last            = 1'b0;
    if (head.cmd.is_start) begin
      cur_x_next          = head.cmd.x0;
      cur_y_next          = head.cmd.y0;
      target_x_next       = head.cmd.x1;
      target_y_next       = head.cmd.y1;
      delta_x_next        = head.cmd.dx;
      delta_y_next        = head.cmd.dy;
      dir_x_negative_next = head.cmd.x_neg;
      dir_y_negative_next = head.cmd.y_neg;
      error_term_next     = head.cmd.err0;
      busy_next           = !head.cmd.zero_len;
      res_valid           = 1'b1;
      res_last            = head.cmd.zero_len;
    end else if (busy) begin
      if (move_x) begin
        cur_x_next = step_x;
      end
      if (move_y) begin
        cur_y_next = step_y;
      end
      error_term_next = error_term - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);
      res_valid       = 1'b1;
      res_last        = (cur_x_next == target_x) && (cur_y_next == target_y);
      busy_next       = !res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy      <= busy_next;
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x          <= '0;
      cur_y          <= '0;
      target_x       <= '0;
      target_y       <= '0;
      delta_x        <= '0;
      delta_y        <= '0;
      dir_x_negative <= 1'b0;
      dir_y_negative <= 1'b0;
      error_term     <= '0;
    end else if (pop) begin
      cur_x          <= cur_x_next;
      cur_y          <= cur_y_next;
      target_x       <= target_x_next;
      target_y       <= target_y_next;
      delta_x        <= delta_x_next;
      delta_y        <= delta_y_next;
      dir_x_negative <= dir_x_negative_next;
      dir_y_negative <= dir_y_negative_next;
      error_term     <= error_term_next;
    end
  end

  // idle step word carries all zero fields
  always_ff @(posedge clk) begin
    if (pop) begin
      out_x           <= res_valid ? lr_pkg::FIELD_W'(cur_x_next) : '0;
      out_y           <= res_valid ? lr_pkg::FIELD_W'(cur_y_next) : '0;
      out_color       <= res_valid ? draw_color : '0;
      out_pixel_valid <= res_valid;
      out_last        <= res_last;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_color = out_color;
  assign pix.pixel_valid = out_pixel_valid;
  assign pix.last_pixel  = out_last;

endmodule

// File: src/line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
//   channel  dir  payload                                   handshake
//   cmd      in   opcode, start_x, start_y, end_x, end_y    valid/ready
//   pixel    out  pixel_x, pixel_y, pixel_color,            valid/ready
//                 pixel_valid, last_pixel
//   cfg      in   cfg_data (draw_color)                     cfg_we
//
// One command word per clock while the queue is not full, one pixel word per
// command word. A command is classified into the two-entry queue, then the
// stepper loads the output register. A line moves one pixel per STEP word.
// rst (synchronous) clears the queue, the output valid and the line state.
// A stalled pixel output holds its word; the queue keeps cmd ready until full.
module line_rasterizer (
  input  logic                       clk,
  input  logic                       rst,
  lr_cmd_if.sink                     cmd,
  lr_pix_if.source                   pixel,
  input  logic                       cfg_we,
  input  logic [lr_pkg::COLOR_W-1:0] cfg_data
);

  logic [lr_pkg::COLOR_W-1:0] draw_color;
  lr_pkg::cmd_word_t          push, head;
  logic                       q_full, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= '0;
    end else if (cfg_we) begin
      draw_color <= cfg_data;
    end
  end

  lr_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .push   (push)
  );

  lr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  lr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .draw_color (draw_color),
    .pop        (pop),
    .pix        (pixel)
  );

endmodule

// File: src/lr_checker.sv
// Port-level checks for the line rasterizer, bound to the top level.
module lr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       pix_valid,
  input logic                       pix_ready,
  input logic [lr_pkg::FIELD_W-1:0] pixel_x,
  input logic [lr_pkg::FIELD_W-1:0] pixel_y,
  input logic [lr_pkg::COLOR_W-1:0] pixel_color,
  input logic                       pixel_valid,
  input logic                       last_pixel
);

  // a stalled word stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_ready) |=> (pix_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_color) && $stable(pixel_valid) && $stable(last_pixel)))
    else $error("pixel word changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pixel_valid) |-> (pixel_x == '0 && pixel_y == '0
      && pixel_color == '0 && !last_pixel))
    else $error("idle step word has nonzero fields");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && last_pixel) |-> pixel_valid)
    else $error("last_pixel on a word without a pixel");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel word right after reset");

  // a new word must follow a handshake through the queue and output reg
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($rose(pix_valid) && !$past(rst) && !$past(rst, 2)) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("pixel word without a command two cycles earlier");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .pix_valid   (pixel.valid),
  .pix_ready   (pixel.ready),
  .pixel_x     (pixel.pixel_x),
  .pixel_y     (pixel.pixel_y),
  .pixel_color (pixel.pixel_color),
  .pixel_valid (pixel.pixel_valid),
  .last_pixel  (pixel.last_pixel)
);
